// ===== hw/rtl/lph_pkg.sv =====
// shared types and constants for the landmark pair hasher
package lph_pkg;

    localparam int PEAK_TIME_W = 20;
    localparam int PEAK_FREQ_W = 12;
    localparam int FREQ_W      = 10;
    localparam int DELTA_W     = 12;
    localparam int SONG_W      = 16;
    localparam int HASH_W      = 32;
    localparam int COUNT_W     = 24;

    localparam logic [COUNT_W-1:0] COUNT_MAX = 24'hFFFFFF;

    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    localparam logic [1:0] REG_DELTA_MIN = 2'd0;
    localparam logic [1:0] REG_DELTA_MAX = 2'd1;
    localparam logic [1:0] REG_SONG_ID   = 2'd2;

    localparam logic [DELTA_W-1:0] DELTA_MIN_RST = 12'd0;
    localparam logic [DELTA_W-1:0] DELTA_MAX_RST = 12'd200;
    localparam logic [SONG_W-1:0]  SONG_ID_RST   = 16'd0;

    typedef struct packed {
        logic [PEAK_TIME_W-1:0] peak_time;
        logic [PEAK_FREQ_W-1:0] peak_freq;
        logic                   last_peak;
    } peak_t;

    typedef struct packed {
        logic [HASH_W-1:0]      hash_value;
        logic [PEAK_TIME_W-1:0] anchor_frame;
        logic [SONG_W-1:0]      hash_song;
        logic                   hash_valid;
        logic                   last_result;
        logic [COUNT_W-1:0]     hash_total;
    } result_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PAIR,
        ST_POP,
        ST_END
    } state_t;

    typedef struct packed {
        logic accept;
        logic rotate;
        logic pop;
        logic eval;
        logic finish;
        logic flush;
    } ctrl_t;

    typedef struct packed {
        logic pair_ok;
        logic end_ok;
    } emit_stat_t;

endpackage

// ===== hw/rtl/landmark_pair_hasher_core.sv =====
// landmark pair hasher top level: config registers, cell chain, sequencer and output stage
// steps: a peak that fills no anchor is only accepted; one that completes an anchor is
//   accepted, paired in a pass over the rotating cell chain, then ends its step
// the last peak of a list also flushes the window with up to FAN pops, each anchor a pass
// results leave via a hold stage and an output register, at most one beat per pairing cycle
// reset (synchronous, active low) empties the window, clears the count, sets config defaults
module landmark_pair_hasher_core #(
    parameter int FAN       = 8,
    parameter int TIME_BITS = 20
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  lph_pkg::peak_t                     s_data,
    output logic                               m_valid,
    input  logic                               m_ready,
    output lph_pkg::result_t                   m_data,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [lph_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [lph_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [lph_pkg::APB_DATA_W-1:0]     prdata,
    output logic                               pready
);
    import lph_pkg::*;

    localparam int TW = (TIME_BITS < PEAK_TIME_W) ? TIME_BITS : PEAK_TIME_W;

    logic [DELTA_W-1:0] delta_min_reg;
    logic [DELTA_W-1:0] delta_max_reg;
    logic [SONG_W-1:0]  song_id_reg;
    logic               cfg_wr;
    logic [1:0]         cfg_idx;

    ctrl_t              ctl;
    emit_stat_t         stat;

    logic               cvld [FAN];
    logic [TW-1:0]      ctm  [FAN];
    logic [FREQ_W-1:0]  cfq  [FAN];
    logic               tail_vld;
    logic [TW-1:0]      tail_tm;
    logic [FREQ_W-1:0]  tail_fq;
    logic               move;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[3:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            delta_min_reg <= DELTA_MIN_RST;
            delta_max_reg <= DELTA_MAX_RST;
            song_id_reg   <= SONG_ID_RST;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_DELTA_MIN: delta_min_reg <= pwdata[DELTA_W-1:0];
                REG_DELTA_MAX: delta_max_reg <= pwdata[DELTA_W-1:0];
                REG_SONG_ID:   song_id_reg   <= pwdata[SONG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            REG_DELTA_MIN: prdata = APB_DATA_W'(delta_min_reg);
            REG_DELTA_MAX: prdata = APB_DATA_W'(delta_max_reg);
            REG_SONG_ID:   prdata = APB_DATA_W'(song_id_reg);
            default:       prdata = '0;
        endcase
    end

    assign move = ctl.accept || ctl.pop || ctl.rotate;

    always_comb begin
        tail_vld = cvld[0];
        tail_tm  = ctm[0];
        tail_fq  = cfq[0];
        if (ctl.accept) begin
            tail_vld = 1'b1;
            tail_tm  = s_data.peak_time[TW-1:0];
            tail_fq  = s_data.peak_freq[FREQ_W-1:0];
        end else if (ctl.pop) begin
            tail_vld = 1'b0;
        end
    end

    for (genvar i = 0; i < FAN; i++) begin : g_chain
        if (i == FAN - 1) begin : g_tail
            lph_cell #(.TW(TW)) u_cell (
                .aclk    (aclk),
                .aresetn (aresetn),
                .move    (move),
                .in_vld  (tail_vld),
                .in_tm   (tail_tm),
                .in_fq   (tail_fq),
                .vld     (cvld[i]),
                .tm      (ctm[i]),
                .fq      (cfq[i])
            );
        end else begin : g_body
            lph_cell #(.TW(TW)) u_cell (
                .aclk    (aclk),
                .aresetn (aresetn),
                .move    (move),
                .in_vld  (cvld[i+1]),
                .in_tm   (ctm[i+1]),
                .in_fq   (cfq[i+1]),
                .vld     (cvld[i]),
                .tm      (ctm[i]),
                .fq      (cfq[i])
            );
        end
    end

    lph_ctrl #(.FAN(FAN)) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_last   (s_data.last_peak),
        .head_vld (cvld[0]),
        .stat     (stat),
        .s_ready  (s_ready),
        .ctl      (ctl)
    );

    lph_emit #(.TW(TW)) u_emit (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctl       (ctl),
        .head_vld  (cvld[0]),
        .head_tm   (ctm[0]),
        .head_fq   (cfq[0]),
        .delta_min (delta_min_reg),
        .delta_max (delta_max_reg),
        .song_id   (song_id_reg),
        .m_ready   (m_ready),
        .m_valid   (m_valid),
        .m_data    (m_data),
        .stat      (stat)
    );

endmodule

// ===== hw/rtl/lph_cell.sv =====
// one window cell: holds a peak and passes it to its neighbor when the chain moves
module lph_cell #(
    parameter int TW = 20
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             move,
    input  logic                             in_vld,
    input  logic [TW-1:0]                    in_tm,
    input  logic [lph_pkg::FREQ_W-1:0]       in_fq,
    output logic                             vld,
    output logic [TW-1:0]                    tm,
    output logic [lph_pkg::FREQ_W-1:0]       fq
);
    import lph_pkg::*;

    logic              vld_reg;
    logic [TW-1:0]     tm_reg;
    logic [FREQ_W-1:0] fq_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (move) begin
            vld_reg <= in_vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (move) begin
            tm_reg <= in_tm;
            fq_reg <= in_fq;
        end
    end

    assign vld = vld_reg;
    assign tm  = tm_reg;
    assign fq  = fq_reg;

endmodule

// ===== hw/rtl/lph_ctrl.sv =====
// sequencer: accept, pairing pass over the chain, flush pops and end of step
module lph_ctrl #(
    parameter int FAN = 8
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    input  logic                s_last,
    input  logic                head_vld,
    input  lph_pkg::emit_stat_t stat,
    output logic                s_ready,
    output lph_pkg::ctrl_t      ctl
);
    import lph_pkg::*;

    localparam int CW = $clog2(FAN + 1);

    state_t          state_reg;
    state_t          state_next;
    logic [CW-1:0]   rot_cnt_reg;
    logic [CW-1:0]   pop_cnt_reg;
    logic            last_reg;
    logic            rot_done;

    assign rot_done = (rot_cnt_reg == CW'(FAN - 1));

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    if (head_vld) begin
                        state_next = ST_PAIR;
                    end else if (s_last) begin
                        state_next = ST_POP;
                    end
                end
            end
            ST_PAIR: begin
                if (stat.pair_ok && rot_done) begin
                    if (last_reg && (pop_cnt_reg != CW'(FAN))) begin
                        state_next = ST_POP;
                    end else begin
                        state_next = ST_END;
                    end
                end
            end
            ST_POP: begin
                if (head_vld) begin
                    state_next = ST_PAIR;
                end else if (pop_cnt_reg == CW'(FAN - 1)) begin
                    state_next = ST_END;
                end
            end
            ST_END: begin
                if (stat.end_ok) begin
                    state_next = ST_IDLE;
                end
            end
        endcase
    end

    always_comb begin
        s_ready    = 1'b0;
        ctl        = '0;
        ctl.flush  = last_reg;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready    = 1'b1;
                ctl.accept = s_valid;
            end
            ST_PAIR: begin
                ctl.rotate = stat.pair_ok;
                ctl.eval   = stat.pair_ok;
            end
            ST_POP: begin
                ctl.pop = 1'b1;
            end
            ST_END: begin
                ctl.finish = stat.end_ok;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            rot_cnt_reg <= '0;
            pop_cnt_reg <= '0;
            last_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (ctl.accept) begin
                last_reg <= s_last;
            end
            if (ctl.rotate) begin
                rot_cnt_reg <= rot_done ? '0 : rot_cnt_reg + 1'b1;
            end
            if (ctl.pop) begin
                pop_cnt_reg <= pop_cnt_reg + 1'b1;
            end
            if (ctl.finish) begin
                pop_cnt_reg <= '0;
                last_reg    <= 1'b0;
            end
        end
    end

`ifndef SYNTH
    a_rot_only_in_pair: assert property (@(posedge aclk) disable iff (!aresetn)
        (rot_cnt_reg != '0) |-> (state_reg == ST_PAIR))
        else $error("rotation count left running outside a pairing pass");

    a_pop_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        pop_cnt_reg <= CW'(FAN))
        else $error("more flush pops than window cells");

    a_pop_only_flush: assert property (@(posedge aclk) disable iff (!aresetn)
        (pop_cnt_reg != '0) |-> last_reg)
        else $error("flush pops outside a last-peak step");
`endif

endmodule

// ===== hw/rtl/lph_emit.sv =====
// pair check, hash build, one-deep hold stage, output register and hash counter
module lph_emit #(
    parameter int TW = 20
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  lph_pkg::ctrl_t                    ctl,
    input  logic                              head_vld,
    input  logic [TW-1:0]                     head_tm,
    input  logic [lph_pkg::FREQ_W-1:0]        head_fq,
    input  logic [lph_pkg::DELTA_W-1:0]       delta_min,
    input  logic [lph_pkg::DELTA_W-1:0]       delta_max,
    input  logic [lph_pkg::SONG_W-1:0]        song_id,
    input  logic                              m_ready,
    output logic                              m_valid,
    output lph_pkg::result_t                  m_data,
    output lph_pkg::emit_stat_t               stat
);
    import lph_pkg::*;

    logic [TW-1:0]      anchor_tm_reg;
    logic [FREQ_W-1:0]  anchor_fq_reg;
    logic               hold_vld_reg;
    result_t            hold_reg;
    logic               out_vld_reg;
    logic               out_vld_next;
    result_t            out_reg;
    logic [COUNT_W-1:0] cnt_reg;

    logic [TW:0]        diff;
    logic [TW-1:0]      mag;
    logic               keep;
    logic [COUNT_W-1:0] cnt_inc;
    logic               out_free;
    logic               produce;
    result_t            new_res;
    result_t            marker;
    result_t            held_res;

    assign diff    = {1'b0, head_tm} - {1'b0, anchor_tm_reg};
    assign mag     = diff[TW-1:0];
    assign keep    = head_vld && !diff[TW] && (mag >= TW'(delta_min)) &&
                     (mag <= TW'(delta_max));
    assign cnt_inc = (cnt_reg == COUNT_MAX) ? cnt_reg : cnt_reg + 1'b1;
    assign produce = ctl.eval && keep;

    assign out_free = !out_vld_reg || m_ready;
    assign stat     = '{pair_ok: (!hold_vld_reg || out_free), end_ok: out_free};

    always_comb begin
        new_res              = '0;
        new_res.hash_value   = {anchor_fq_reg, head_fq, mag[DELTA_W-1:0]};
        new_res.anchor_frame = PEAK_TIME_W'(anchor_tm_reg);
        new_res.hash_song    = song_id;
        new_res.hash_valid   = 1'b1;
        new_res.last_result  = 1'b0;
        new_res.hash_total   = cnt_inc;

        marker              = '0;
        marker.hash_song    = song_id;
        marker.last_result  = 1'b1;
        marker.hash_total   = cnt_reg;

        held_res             = hold_reg;
        held_res.last_result = ctl.flush;
    end

    always_comb begin
        out_vld_next = out_vld_reg && !m_ready;
        if ((produce && hold_vld_reg) || (ctl.finish && (hold_vld_reg || ctl.flush))) begin
            out_vld_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_vld_reg <= 1'b0;
            out_vld_reg  <= 1'b0;
            cnt_reg      <= '0;
        end else begin
            out_vld_reg <= out_vld_next;
            if (produce) begin
                cnt_reg      <= cnt_inc;
                hold_vld_reg <= 1'b1;
            end
            if (ctl.finish) begin
                hold_vld_reg <= 1'b0;
                if (ctl.flush) begin
                    cnt_reg <= '0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.accept || ctl.pop) begin
            anchor_tm_reg <= head_tm;
            anchor_fq_reg <= head_fq;
        end
        if (produce) begin
            hold_reg <= new_res;
            if (hold_vld_reg) begin
                out_reg <= hold_reg;
            end
        end
        if (ctl.finish) begin
            out_reg <= hold_vld_reg ? held_res : marker;
        end
    end

    assign m_valid = out_vld_reg;
    assign m_data  = out_reg;

`ifndef SYNTH
    a_hold_push_room: assert property (@(posedge aclk) disable iff (!aresetn)
        (produce && hold_vld_reg) |-> out_free)
        else $error("held beat pushed into a full output register");

    a_count_cleared: assert property (@(posedge aclk) disable iff (!aresetn)
        (ctl.finish && ctl.flush) |=> (cnt_reg == '0))
        else $error("hash count not cleared at end of list");

    a_hold_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.finish |=> !hold_vld_reg)
        else $error("hold stage not drained at end of step");
`endif

endmodule
